// ===== rtl/ky_pkg.sv =====
// ----------------------------------------------------------------------------
// ky_pkg
// Shared types and constants for the Knuth-Yao Gaussian sampler pipeline.
// ----------------------------------------------------------------------------
package ky_pkg;

    // default table geometry
    localparam int PRECISION_DEF = 32;
    localparam int RANGE_DEF     = 64;

    // fixed field widths
    localparam int COL_W   = 5;
    localparam int SLOT_W  = 6;
    localparam int TVAL_W  = 7;
    localparam int BITS_W  = 34;
    localparam int COUNT_W = 7;
    localparam int LEAF_W  = 6;
    localparam int NODE_W  = 8;
    localparam int CFG_W   = 6;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_LOAD_COUNT = 2'd0,
        ACT_LOAD_LEAF  = 2'd1,
        ACT_SAMPLE     = 2'd2
    } action_t;

    // state of one sample as it walks down the columns
    typedef struct packed {
        logic                valid;
        logic                started;
        logic                done;
        logic                err;
        logic [NODE_W-1:0]   node;
        logic [BITS_W-1:0]   bits;
        logic [COL_W-1:0]    leaf_col;
        logic [SLOT_W-1:0]   leaf_idx;
        logic                last;
    } walk_t;

endpackage

// ===== rtl/knuth_yao_gaussian_sampler.sv =====
// ----------------------------------------------------------------------------
// knuth_yao_gaussian_sampler
// Pipelined Knuth-Yao discrete Gaussian sampler with loadable tables.
// ----------------------------------------------------------------------------
// channel | direction | content
// s_*     | in        | tuser action, tdata load/sample fields, tlast last_request
// m_*     | out       | tdata sample_value and status, tlast last
// cfg_*   | in        | columns_in_use write
//
// one column per stage, PRECISION stages then a leaf RAM read stage; samples
// are accepted one per cycle while the result side does not stall.
// table loads are held off until the pipeline has drained.
// a stall on the result side freezes every stage; nothing is lost or repeated.
// reset clears valid bits and columns_in_use (to its maximum); tables are not
// cleared.
// ----------------------------------------------------------------------------
module knuth_yao_gaussian_sampler #(
    parameter int PRECISION = ky_pkg::PRECISION_DEF,
    parameter int RANGE     = ky_pkg::RANGE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // column[4:0], slot[10:5], table_value[17:11], random_bits[51:18], zero fill
    input  logic [55:0]               s_tdata,
    // action[1:0]
    input  logic [1:0]                s_tuser,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // sample_value[6:0], status[7]
    output logic [7:0]                m_tdata,
    output logic                      m_tlast,
    input  logic                      cfg_we,
    input  logic [ky_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(PRECISION * RANGE);
    localparam int CW = $clog2(PRECISION);

    logic [ky_pkg::CFG_W-1:0]   cols_reg;
    logic [ky_pkg::CFG_W-1:0]   cols_next;
    logic [ky_pkg::COUNT_W-1:0] counts_reg [PRECISION];
    ky_pkg::walk_t              walk_in;
    ky_pkg::walk_t              walk [PRECISION];
    logic [PRECISION-1:0]       walk_valid;
    logic                       advance;
    logic                       busy;
    logic                       accept;
    logic                       is_sample;
    logic [ky_pkg::COL_W-1:0]   ld_col;
    logic [ky_pkg::SLOT_W-1:0]  ld_slot;
    logic [ky_pkg::TVAL_W-1:0]  ld_val;
    logic                       col_ok;
    logic                       leaf_we;
    logic [AW-1:0]              leaf_waddr;
    logic [AW-1:0]              leaf_raddr;
    logic [ky_pkg::LEAF_W-1:0]  leaf_rdata;
    logic                       out_valid_reg;
    logic                       out_err_reg;
    logic                       out_sign_reg;
    logic                       out_last_reg;
    logic [6:0]                 mag_ext;

    // input field unpacking
    assign ld_col  = s_tdata[4:0];
    assign ld_slot = s_tdata[10:5];
    assign ld_val  = s_tdata[17:11];
    assign col_ok  = ({1'b0, ld_col} < ky_pkg::CFG_W'(PRECISION));

    // flow control
    assign advance   = !out_valid_reg || m_tready;
    assign busy      = out_valid_reg || (|walk_valid);
    assign is_sample = (s_tuser == ky_pkg::ACT_SAMPLE);
    assign s_tready  = advance && (is_sample || !busy);
    assign accept    = s_tvalid && s_tready;

    // columns_in_use register with clamping
    always_comb
    begin
        cols_next = cols_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cols_next = ky_pkg::CFG_W'(1);
            end
            else if (cfg_wdata > ky_pkg::CFG_W'(PRECISION))
            begin
                cols_next = ky_pkg::CFG_W'(PRECISION);
            end
            else
            begin
                cols_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= ky_pkg::CFG_W'(PRECISION < 32 ? PRECISION : 32);
        end
        else
        begin
            cols_reg <= cols_next;
        end
    end

    // internal count table
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == ky_pkg::ACT_LOAD_COUNT && col_ok)
        begin
            counts_reg[ld_col[CW-1:0]] <= ld_val;
        end
    end

    // leaf table writes
    assign leaf_we    = accept && (s_tuser == ky_pkg::ACT_LOAD_LEAF) && col_ok
                        && ({1'b0, ld_slot} < 7'(RANGE));
    assign leaf_waddr = AW'(int'(ld_col) * RANGE + int'(ld_slot));

    // pipeline entry
    always_comb
    begin
        walk_in          = '0;
        walk_in.valid    = accept && is_sample;
        walk_in.bits     = s_tdata[51:18];
        walk_in.last     = s_tlast;
    end

    // one stage per column, top column first
    for (genvar i = 0; i < PRECISION; i++)
    begin : g_stage
        ky_stage #(
            .RANGE  (RANGE),
            .COLUMN (PRECISION - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cols     (cols_reg),
            .count    (counts_reg[PRECISION - 1 - i]),
            .walk_in  ((i == 0) ? walk_in : walk[(i == 0) ? 0 : i - 1]),
            .walk_out (walk[i])
        );
        assign walk_valid[i] = walk[i].valid;
    end

    // leaf read stage
    assign leaf_raddr = AW'(int'(walk[PRECISION-1].leaf_col) * RANGE
                            + int'(walk[PRECISION-1].leaf_idx));

    ky_ram #(
        .WIDTH (ky_pkg::LEAF_W),
        .DEPTH (PRECISION * RANGE)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (ld_val[ky_pkg::LEAF_W-1:0]),
        .re    (advance),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= walk[PRECISION-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_err_reg  <= walk[PRECISION-1].err;
            out_sign_reg <= walk[PRECISION-1].bits[0];
            out_last_reg <= walk[PRECISION-1].last;
        end
    end

    // result transaction
    assign mag_ext  = {1'b0, leaf_rdata};
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_err_reg,
                       out_err_reg  ? 7'd0 :
                       out_sign_reg ? mag_ext : 7'(-mag_ext)};

    // a walk leaving the last column has always finished
    assert property (@(posedge clk) disable iff (!rst_n)
        walk[PRECISION-1].valid |-> walk[PRECISION-1].done)
        else $error("walk left the pipeline unfinished");

    // an error result carries a zero sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[6:0] == 7'd0))
        else $error("error result with non-zero sample");

    // columns_in_use stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (cols_reg != '0) && (cols_reg <= ky_pkg::CFG_W'(PRECISION)))
        else $error("columns_in_use out of range");

    // a table load never overtakes a sample in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_sample) |-> !busy)
        else $error("table load while samples in flight");

endmodule

// ===== rtl/ky_ram.sv =====
// ----------------------------------------------------------------------------
// ky_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ky_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ky_stage.sv =====
// ----------------------------------------------------------------------------
// ky_stage
// One column of the walk: start, descend one level, or stop on a leaf or an error.
// ----------------------------------------------------------------------------
module ky_stage #(
    parameter int RANGE  = ky_pkg::RANGE_DEF,
    parameter int COLUMN = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [ky_pkg::CFG_W-1:0]    cols,
    input  logic [ky_pkg::COUNT_W-1:0]  count,
    input  ky_pkg::walk_t               walk_in,
    output ky_pkg::walk_t               walk_out
);

    ky_pkg::walk_t               walk_next;
    ky_pkg::walk_t               walk_reg;
    logic                        valid_reg;
    logic [ky_pkg::NODE_W-1:0]   diff;

    // walk step for this column
    always_comb
    begin
        walk_next = walk_in;
        diff      = '0;
        if (walk_next.valid && !walk_next.started
            && (cols - 1'b1) == ky_pkg::CFG_W'(COLUMN))
        begin
            walk_next.started = 1'b1;
            walk_next.node    = {{(ky_pkg::NODE_W-1){1'b0}}, walk_next.bits[0]};
            walk_next.bits    = walk_next.bits >> 1;
        end
        if (walk_next.valid && walk_next.started && !walk_next.done)
        begin
            if (walk_next.node < {1'b0, count})
            begin
                walk_next.node = {walk_next.node[ky_pkg::NODE_W-2:0], walk_next.bits[0]};
                walk_next.bits = walk_next.bits >> 1;
                if (COLUMN == 0)
                begin
                    walk_next.err  = 1'b1;
                    walk_next.done = 1'b1;
                end
            end
            else
            begin
                diff               = walk_next.node - {1'b0, count};
                walk_next.done     = 1'b1;
                walk_next.leaf_col = ky_pkg::COL_W'(COLUMN);
                if (diff >= ky_pkg::NODE_W'(RANGE))
                begin
                    walk_next.err = 1'b1;
                end
                else
                begin
                    walk_next.leaf_idx = diff[ky_pkg::SLOT_W-1:0];
                end
            end
        end
    end

    // stage valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= walk_next.valid;
        end
    end

    // stage data register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            walk_reg <= walk_next;
        end
    end

    always_comb
    begin
        walk_out       = walk_reg;
        walk_out.valid = valid_reg;
    end

endmodule

// ===== verif/tb_knuth_yao_gaussian_sampler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_knuth_yao_gaussian_sampler
// Self-checking bench for the Knuth-Yao sampler: table loads and sample draws
// are streamed in bursts with random gaps, the result side stalls on a
// rotating pattern, and each sample is checked against a walk computed here.
// ----------------------------------------------------------------------------
module tb_knuth_yao_gaussian_sampler;

    localparam int          NCOL       = 32;
    localparam int          NSLOT      = 64;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [4:0]  column;
        logic [5:0]  slot;
        logic [6:0]  tval;
        logic [33:0] bits;
        logic        last_req;
    } ky_item_t;

    typedef struct {
        logic [6:0] value;
        logic       status;
        logic       last;
    } ky_sample_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;

    // tables as the planner sees them (for steering clear of unwritten leaves)
    logic [6:0]  plan_count [NCOL];
    logic [5:0]  plan_leaf  [NCOL*NSLOT];
    bit          leaf_known [NCOL*NSLOT];
    // tables as the block holds them, updated on accepted transactions
    logic [6:0]  blk_count  [NCOL];
    logic [5:0]  blk_leaf   [NCOL*NSLOT];
    int          blk_cols;

    ky_item_t    pending_items[$];
    ky_sample_t  expected_samples[$];
    ky_item_t    cur_item;
    int          burst_left;
    int          gap_left;
    logic [15:0] ready_pattern;
    int          errors;

    knuth_yao_gaussian_sampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // walk down the columns; leaf_at is -1 when no leaf is read
    function automatic void walk_gaussian(input logic [6:0] cnt [NCOL],
                                          input logic [5:0] lf [NCOL*NSLOT],
                                          input int cols, input logic [33:0] bits,
                                          output logic err, output logic [6:0] val,
                                          output int leaf_at);
        int pos;
        int node;
        int clm;
        int idx;
        logic [6:0] mag;
        pos     = 1;
        node    = bits[0];
        clm     = cols - 1;
        err     = 1'b0;
        val     = '0;
        leaf_at = -1;
        while (node < cnt[clm])
        begin
            node = 2 * node + bits[pos];
            pos++;
            if (clm == 0)
            begin
                err = 1'b1;
                break;
            end
            clm--;
        end
        if (!err)
        begin
            idx = node - cnt[clm];
            if (idx >= NSLOT)
                err = 1'b1;
            else
            begin
                leaf_at = clm * NSLOT + idx;
                mag     = {1'b0, lf[leaf_at]};
                val     = bits[pos] ? mag : 7'(-mag);
            end
        end
    endfunction

    function automatic int clamp_cols(input logic [5:0] v);
        if (v == 0)
            return 1;
        if (v > NCOL)
            return NCOL;
        return v;
    endfunction

    // driver: bursts of transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       err;
        logic [6:0] val;
        int         leaf_at;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // update the block's view on acceptance
            if (s_tvalid && s_tready)
            begin
                case (cur_item.act)
                    ky_pkg::ACT_LOAD_COUNT: blk_count[cur_item.column] = cur_item.tval;
                    ky_pkg::ACT_LOAD_LEAF:
                        blk_leaf[cur_item.column * NSLOT + cur_item.slot] = cur_item.tval[5:0];
                    ky_pkg::ACT_SAMPLE:
                    begin
                        walk_gaussian(blk_count, blk_leaf, blk_cols, cur_item.bits,
                                      err, val, leaf_at);
                        expected_samples.push_back('{value: val, status: err,
                                                     last: cur_item.last_req});
                    end
                    default: ;
                endcase
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cur_item.bits, cur_item.tval, cur_item.slot,
                                 cur_item.column};
                    s_tuser  <= cur_item.act;
                    s_tlast  <= cur_item.last_req;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks results and drives the stall pattern
    always @(posedge clk or negedge rst_n)
    begin : monitor
        ky_sample_t want;
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            ready_pattern <= 16'hffff;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample value=%0d status=%0d last=%0d",
                             $time, $signed(m_tdata[6:0]), m_tdata[7], m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata[6:0] !== want.value)
                    begin
                        $display("%0t: sample_value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(m_tdata[6:0]));
                        errors++;
                    end
                    if (m_tdata[7] !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tdata[7]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, m_tlast);
                        errors++;
                    end
                end
            end
            // rotate the stall pattern, now and then pick a new one
            if ($urandom_range(0, 63) == 0)
                ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
            else
                ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            m_tready <= ready_pattern[15];
        end
    end

    // queue one load of the internal count table
    task automatic plan_count_load(input int col, input logic [6:0] v);
        pending_items.push_back('{act: ky_pkg::ACT_LOAD_COUNT, column: 5'(col),
                                  slot: 6'($urandom),
                                  tval: v, bits: {2'($urandom), 32'($urandom)},
                                  last_req: 1'($urandom)});
        plan_count[col] = v;
    endtask

    task automatic plan_leaf_load(input int col, input int slot, input logic [6:0] v);
        pending_items.push_back('{act: ky_pkg::ACT_LOAD_LEAF, column: 5'(col),
                                  slot: 6'(slot), tval: v,
                                  bits: {2'($urandom), 32'($urandom)},
                                  last_req: 1'($urandom)});
        plan_leaf[col * NSLOT + slot]  = v[5:0];
        leaf_known[col * NSLOT + slot] = 1'b1;
    endtask

    // queue a sample, loading the leaf it lands on first if still unwritten
    task automatic plan_sample(input int cols, input logic [33:0] bits, input logic lr);
        logic       err;
        logic [6:0] val;
        int         leaf_at;
        walk_gaussian(plan_count, plan_leaf, cols, bits, err, val, leaf_at);
        if (leaf_at >= 0 && !leaf_known[leaf_at])
            plan_leaf_load(leaf_at / NSLOT, leaf_at % NSLOT, 7'($urandom));
        pending_items.push_back('{act: ky_pkg::ACT_SAMPLE, column: 5'($urandom),
                                  slot: 6'($urandom),
                                  tval: 7'($urandom), bits: bits, last_req: lr});
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_samples.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_columns(input logic [5:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        blk_cols = clamp_cols(v);
    endtask

    // stimulus
    initial
    begin : stimulus
        int         cols;
        int         style;
        int         n;
        logic [5:0] cfg_list [7];
        errors    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        blk_cols  = NCOL;
        cols      = NCOL;
        cfg_list  = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd33, 6'd2, 6'd17};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full count table, leaf extremes, sample extremes
        for (int c = 0; c < NCOL; c++)
            plan_count_load(c, 7'($urandom_range(0, 2)));
        plan_count_load(NCOL - 1, 7'd0);
        plan_leaf_load(NCOL - 1, 0, 7'd127);
        plan_leaf_load(NCOL - 1, 1, 7'd0);
        plan_leaf_load(0, NSLOT - 1, 7'd64);
        plan_sample(cols, 34'h0, 1'b0);
        plan_sample(cols, 34'h3_ffff_ffff, 1'b1);
        plan_sample(cols, 34'h2, 1'b0);
        plan_leaf_load(NCOL - 1, 0, 7'd0);
        plan_sample(cols, 34'h0, 1'b1);
        pending_items.push_back('{act: ACT_UNUSED, column: 5'd31, slot: 6'd63,
                                  tval: 7'd127, bits: 34'h3_ffff_ffff, last_req: 1'b1});
        plan_sample(cols, 34'h1, 1'b0);

        // phases, each writing a column count and loading a count table of one of three shapes
        for (int ph = 0; ph < 7; ph++)
        begin
            write_columns(cfg_list[ph]);
            cols = clamp_cols(cfg_list[ph]);
            style = ph % 3;
            for (int c = 0; c < NCOL; c++)
                plan_count_load(c, (style == 0) ? 7'($urandom_range(0, 3)) :
                                   (style == 1) ? 7'($urandom_range(0, 12)) :
                                   ($urandom_range(0, 4) == 0) ? 7'd127 :
                                                                 7'($urandom_range(0, 40)));
            // a deep table somewhere forces walks off the bottom
            if (ph == 0)
                plan_count_load(0, 7'd127);
            n = (ph == 6) ? 3 : $urandom_range(100, 140);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       plan_count_load($urandom_range(0, NCOL - 1),
                                             7'($urandom_range(0, 6)));
                    1:       plan_leaf_load($urandom_range(0, NCOL - 1),
                                            $urandom_range(0, NSLOT - 1), 7'($urandom));
                    2:       pending_items.push_back('{act: ACT_UNUSED, column: 5'($urandom),
                                 slot: 6'($urandom), tval: 7'($urandom),
                                 bits: {2'($urandom), 32'($urandom)},
                                 last_req: 1'($urandom)});
                    default: plan_sample(cols, {2'($urandom), 32'($urandom)},
                                         ($urandom_range(0, 7) == 0));
                endcase
            end
        end
        // last phase back to the full column count with a long random run
        write_columns(6'd32);
        for (int i = 0; i < 300; i++)
            plan_sample(NCOL, {2'($urandom), 32'($urandom)}, 1'($urandom));

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_samples.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ky_pkg.sv
rtl/ky_ram.sv
rtl/ky_stage.sv
rtl/knuth_yao_gaussian_sampler.sv
verif/tb_knuth_yao_gaussian_sampler.sv
